### src/text_console_cursor_writer_unit_defines.svh
// Assertion macros for the text console cursor writer.
// Depends on nothing; included by modules that carry assertions.
`ifndef TEXT_CONSOLE_CURSOR_WRITER_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_WRITER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Clocked check, masked while reset is asserted
`define TCCW_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("tccw check failed");
// Clocked check that also holds through reset
`define TCCW_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) (prop)) \
        else $error("tccw check failed");
`else
`define TCCW_ASSERT(label, prop)
`define TCCW_ASSERT_ALWAYS(label, prop)
`endif

`endif

### src/tccw_pkg.sv
// Shared constants for the text console cursor writer.
// No dependencies; imported by text_console_cursor_writer_unit.
package tccw_pkg;

    // Screen geometry and tab spacing
    localparam int SCREEN_COLS = 80;
    localparam int SCREEN_ROWS = 25;
    localparam int TAB_STOP    = 4;
    localparam int MAX_RESULTS = 5;

    // Internal cursor widths (hold one past the edge)
    localparam int COL_W = $clog2(SCREEN_COLS + 1);
    localparam int ROW_W = $clog2(SCREEN_ROWS + 1);
    localparam int TAB_W = $clog2(TAB_STOP + 1);
    localparam int CNT_W = $clog2(MAX_RESULTS + 1);

    // Beat field widths
    localparam int ROW_FIELD_W  = 5;
    localparam int COL_FIELD_W  = 7;
    localparam int BYTE_W       = 8;
    localparam int COLOUR_W     = 4;
    localparam int IN_TDATA_W   = 32;
    localparam int OUT_TDATA_W  = 32;

    // Character codes
    localparam logic [BYTE_W-1:0] CH_TAB     = 8'd9;
    localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [BYTE_W-1:0] CH_RETURN  = 8'd13;
    localparam logic [BYTE_W-1:0] CH_SPACE   = 8'd32;

    localparam logic [BYTE_W-1:0]   COLOUR_MAX   = 8'd9;
    localparam logic [BYTE_W-1:0]   ATTR_RESET   = 8'h0F;
    localparam logic [COLOUR_W-1:0] DEF_FG_RESET = 4'd15;
    localparam logic [COLOUR_W-1:0] DEF_BG_RESET = 4'd0;

    // Request kinds and result kinds
    localparam logic REQ_CHAR   = 1'b0;
    localparam logic REQ_COLOUR = 1'b1;
    localparam logic OP_CELL    = 1'b0;
    localparam logic OP_SCROLL  = 1'b1;

    // Configuration register indexes
    localparam logic CFG_DEFAULT_FG = 1'b0;
    localparam logic CFG_DEFAULT_BG = 1'b1;

    // Sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WRAP = 2'd1;
    localparam logic [1:0] ST_PUT  = 2'd2;

    typedef logic [1:0] t_state;

endpackage

### src/text_console_cursor_writer_unit.sv
// Text console cursor writer: cursor, attribute and tab expansion sequencer.
// Depends on tccw_pkg and text_console_cursor_writer_unit_defines.svh.
//
// A colour beat is applied on accept; a character beat runs accept, wrap/scroll step
// and put step, and a tab runs wrap/scroll and put steps once per space, up to 4
// spaces with a tab stop of 4. Each step issues at most one result beat into the
// output register and waits while it is full and not taken. Reset (synchronous,
// active low) sets cursor row 0, column 0, attribute 0x0F, default colours 15 and 0.
`include "text_console_cursor_writer_unit_defines.svh"

module text_console_cursor_writer_unit
    import tccw_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Input stream
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // tdata: char_code[7:0], fg_code[15:8], fg_unused[16], bg_code[24:17],
    //        bg_unused[25], zero[31:26]
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // tuser: req_type[0]
    input  logic                   i_s_axis_tuser,
    // Result stream
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // tdata: cell_row[4:0], cell_col[11:5], glyph[19:12], attribute[27:20],
    //        zero[31:28]
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    // tuser: op_kind[0]
    output logic                   o_m_axis_tuser,
    output logic                   o_m_axis_tlast,
    // Configuration writes
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_idx,
    input  logic [COLOUR_W-1:0]    i_cfg_wdata
);

    // Control state
    t_state             r_state, n_state;
    logic [COL_W-1:0]   r_col, n_col;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [BYTE_W-1:0]  r_attr, n_attr;
    logic [COLOUR_W-1:0] r_def_fg, r_def_bg;
    logic [BYTE_W-1:0]  r_char;
    logic               r_first;
    logic [TAB_W-1:0]   r_n, n_n;
    logic [CNT_W-1:0]   r_cnt;

    // Output register
    logic               r_o_valid;
    logic               r_o_kind;
    logic [ROW_W-1:0]   r_o_row;
    logic [COL_W-1:0]   r_o_col;
    logic [BYTE_W-1:0]  r_o_glyph;
    logic [BYTE_W-1:0]  r_o_attr;
    logic               r_o_last;

    // Shared wrap/scroll unit
    logic               w_wrap;
    logic [COL_W-1:0]   w_col1;
    logic [ROW_W-1:0]   w_row1;
    logic               w_scroll;
    logic [ROW_W-1:0]   w_row2;
    logic [TAB_W-1:0]   w_tab_n;

    logic               w_in_acc;
    logic               w_is_tab;
    logic               w_is_nlcr;
    logic               w_want;
    logic               w_cap_ok;
    logic               w_slot_free;
    logic               w_stall;
    logic               w_emit;
    logic               w_emit_kind;
    logic [BYTE_W-1:0]  w_emit_glyph;
    logic               w_emit_last;
    logic               w_cap_last;

    logic [BYTE_W-1:0]  w_fg_clamp, w_bg_clamp;
    logic [COLOUR_W-1:0] w_fg, w_bg;

    assign w_in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_is_tab  = (r_char == CH_TAB);
    assign w_is_nlcr = (r_char == CH_NEWLINE) || (r_char == CH_RETURN);

    // Wrap past the right edge, then pull the row back if past the bottom
    assign w_wrap   = (r_col >= COL_W'(SCREEN_COLS));
    assign w_col1   = w_wrap ? '0 : r_col;
    assign w_row1   = w_wrap ? r_row + ROW_W'(1) : r_row;
    assign w_scroll = (w_row1 >= ROW_W'(SCREEN_ROWS));
    assign w_row2   = w_scroll ? w_row1 - ROW_W'(1) : w_row1;
    assign w_tab_n  = TAB_W'(TAB_STOP) - TAB_W'(32'(w_col1) % TAB_STOP);

    // Colour clamp
    assign w_fg_clamp = (i_s_axis_tdata[15:8] > COLOUR_MAX) ? COLOUR_MAX
                                                             : i_s_axis_tdata[15:8];
    assign w_bg_clamp = (i_s_axis_tdata[24:17] > COLOUR_MAX) ? COLOUR_MAX
                                                              : i_s_axis_tdata[24:17];
    assign w_fg = i_s_axis_tdata[16] ? r_def_fg : w_fg_clamp[COLOUR_W-1:0];
    assign w_bg = i_s_axis_tdata[25] ? r_def_bg : w_bg_clamp[COLOUR_W-1:0];

    // Result issue: at most one beat per step, extra beats past the cap are dropped
    assign w_cap_ok    = (r_cnt < CNT_W'(MAX_RESULTS));
    assign w_cap_last  = (r_cnt == CNT_W'(MAX_RESULTS - 1));
    assign w_slot_free = !r_o_valid || i_m_axis_tready;
    assign w_want      = ((r_state == ST_WRAP) && w_scroll)
                      || ((r_state == ST_PUT) && !w_is_nlcr);
    assign w_stall     = w_want && w_cap_ok && !w_slot_free;
    assign w_emit      = w_want && w_cap_ok && w_slot_free;
    assign w_emit_kind = (r_state == ST_WRAP) ? OP_SCROLL : OP_CELL;
    assign w_emit_glyph = w_is_tab ? CH_SPACE : r_char;

    always_comb begin
        if (r_state == ST_WRAP) begin
            w_emit_last = (!w_is_tab && w_is_nlcr) || w_cap_last;
        end else begin
            w_emit_last = !w_is_tab || (r_n == TAB_W'(1)) || w_cap_last;
        end
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        n_col   = r_col;
        n_row   = r_row;
        n_attr  = r_attr;
        n_n     = r_n;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_s_axis_tuser == REQ_COLOUR) begin
                        n_attr = {w_bg, w_fg};
                    end else begin
                        n_state = ST_WRAP;
                    end
                end
            end
            ST_WRAP: begin
                if (!w_stall) begin
                    n_col   = w_col1;
                    n_row   = w_row2;
                    n_state = ST_PUT;
                    if (r_first) begin
                        n_n = w_tab_n;
                    end
                end
            end
            ST_PUT: begin
                if (!w_stall) begin
                    if (w_is_tab) begin
                        n_col   = r_col + COL_W'(1);
                        n_n     = r_n - TAB_W'(1);
                        n_state = (r_n == TAB_W'(1)) ? ST_IDLE : ST_WRAP;
                    end else if (r_char == CH_NEWLINE) begin
                        n_row   = r_row + ROW_W'(1);
                        n_col   = '0;
                        n_state = ST_IDLE;
                    end else if (r_char == CH_RETURN) begin
                        n_col   = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_col   = r_col + COL_W'(1);
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_col    <= '0;
            r_row    <= '0;
            r_attr   <= ATTR_RESET;
            r_def_fg <= DEF_FG_RESET;
            r_def_bg <= DEF_BG_RESET;
            r_first  <= 1'b0;
            r_n      <= '0;
            r_cnt    <= '0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
            r_attr  <= n_attr;
            r_n     <= n_n;
            if (w_in_acc) begin
                r_first <= 1'b1;
                r_cnt   <= '0;
            end else begin
                if ((r_state == ST_WRAP) && !w_stall) begin
                    r_first <= 1'b0;
                end
                if (w_emit) begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DEFAULT_FG: r_def_fg <= i_cfg_wdata;
                    CFG_DEFAULT_BG: r_def_bg <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // Capture the character of an accepted beat
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_char <= i_s_axis_tdata[7:0];
        end
    end

    // Output valid: set on issue, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_emit) begin
            r_o_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    // Output payload; a scroll beat carries zeros
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_o_kind <= w_emit_kind;
            r_o_last <= w_emit_last;
            if (w_emit_kind == OP_SCROLL) begin
                r_o_row   <= '0;
                r_o_col   <= '0;
                r_o_glyph <= '0;
                r_o_attr  <= '0;
            end else begin
                r_o_row   <= r_row;
                r_o_col   <= r_col;
                r_o_glyph <= w_emit_glyph;
                r_o_attr  <= r_attr;
            end
        end
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tuser  = r_o_kind;
    assign o_m_axis_tlast  = r_o_last;
    assign o_m_axis_tdata  = {4'b0, r_o_attr, r_o_glyph,
                              COL_FIELD_W'(r_o_col), ROW_FIELD_W'(r_o_row)};

    // Checks
    `TCCW_ASSERT(a_cnt_cap, r_cnt <= CNT_W'(MAX_RESULTS))
    `TCCW_ASSERT(a_idle_on_screen,
        (r_state == ST_IDLE) |-> (r_col <= COL_W'(SCREEN_COLS))
            && (r_row <= ROW_W'(SCREEN_ROWS)))
    `TCCW_ASSERT(a_char_starts_wrap,
        (w_in_acc && (i_s_axis_tuser == REQ_CHAR)) |=> (r_state == ST_WRAP) && r_first)
    `TCCW_ASSERT(a_tab_count_live, ((r_state == ST_PUT) && w_is_tab) |-> (r_n != '0))
    `TCCW_ASSERT(a_scroll_zero,
        (r_o_valid && (r_o_kind == OP_SCROLL)) |-> (r_o_row == '0) && (r_o_col == '0)
            && (r_o_glyph == '0) && (r_o_attr == '0))

endmodule
